// File: hw/rtl/assert_macros.svh
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gsc assertion failed");

// Next-cycle implication.
`define GSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gsc assertion failed");

`endif

// File: hw/rtl/gsc_pkg.sv
package gsc_pkg;

    typedef enum logic [2:0]
    {
        PH_START  = 3'd0,
        PH_BODY   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_TAIL   = 3'd3,
        PH_SKIP   = 3'd4
    } phase_t;

    typedef enum logic [1:0]
    {
        KIND_NONE = 2'd0,
        KIND_NMEA = 2'd1,
        KIND_CRC  = 2'd2
    } kind_t;

    typedef enum logic [2:0]
    {
        ROLE_START   = 3'd0,
        ROLE_DATA    = 3'd1,
        ROLE_SEP     = 3'd2,
        ROLE_STAR    = 3'd3,
        ROLE_DIGIT   = 3'd4,
        ROLE_TAIL    = 3'd5,
        ROLE_IGNORED = 3'd6
    } role_t;

    localparam logic [7:0]  CH_DOLLAR = 8'h24;
    localparam logic [7:0]  CH_HASH   = 8'h23;
    localparam logic [7:0]  CH_STAR   = 8'h2A;
    localparam logic [7:0]  CH_SEMI   = 8'h3B;
    localparam logic [7:0]  CH_COMMA  = 8'h2C;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [3:0]  NEED_NMEA = 4'd2;
    localparam logic [3:0]  NEED_CRC  = 4'd8;
    localparam logic [7:0]  FIELD_MAX = 8'hFF;

    typedef struct packed
    {
        logic       ok;
        logic [3:0] value;
    } nibble_t;

    // One classified byte, front to back.
    typedef struct packed
    {
        logic [7:0] data;
        kind_t      kind;
        role_t      role;
        logic [7:0] field;
        logic       clear;
        logic       sum_en;
        logic       digit_en;
        logic [3:0] nib;
        logic       nib_bad;
        logic       verdict;
        logic       star_seen;
        logic       digits_short;
    } op_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic nibble_t hex_nibble(input logic [7:0] c);
        nibble_t n;
        n.ok    = 1'b1;
        n.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            n.value = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            n.value = 4'(c[3:0] + 4'd9);
        end
        else
        begin
            n.ok = 1'b0;
        end
        return n;
    endfunction

endpackage

// File: hw/rtl/gnss_sentence_checker.sv
// GNSS sentence checker: NMEA XOR-sum and '#' CRC-32 verification with field split.
// Input stream s_*: one sentence character per transfer, s_tlast on its final byte.
// Output stream m_*: exactly one result per input byte, in order, carrying the byte
// echo, its field number and role, and on the last byte of a '$' or '#' sentence the
// verdict (verdict_ready, check_passed, digit_error).
// Config channel cfg_*: one write sets crc_check_enable; cfg_ready is always high.
// A byte taken on s_* goes into a queue entry, then into the output register on m_*.
// Throughput: one byte per cycle, sustained while m_tready is high. It is set by the
// front's phase and field counter update and the back's byte-wide CRC-32 update.
// A two-entry queue sits between the classifying front and the checksum back, and a
// registered output stage follows; when m_tready is low the output holds, the queue
// fills, and s_tready drops once two bytes are waiting.
// Reset: asynchronous, active low. Phase returns to awaiting a start byte, sums clear,
// CRC seeds all ones, crc_check_enable returns to 1, no output pending. No clearing
// pass is needed.
module gnss_sentence_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] field_number, [15:8] byte_echo,
                                   // [16] verdict_ready, [17] check_passed,
                                   // [18] digit_error, [23:19] zero
    output logic [4:0]  m_tuser,   // [1:0] sentence_kind, [4:2] byte_role
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // crc_check_enable
);

    logic         push;
    logic         push_ready;
    gsc_pkg::op_t push_op;
    logic         pop;
    logic         pop_valid;
    gsc_pkg::op_t pop_op;

    assign cfg_ready = 1'b1;

    gsc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_op    (push_op),
        .push_ready (push_ready)
    );

    gsc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_op     (pop_op)
    );

    gsc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .op_valid  (pop_valid),
        .op        (pop_op),
        .op_pop    (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: hw/rtl/gsc_queue.sv
module gsc_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gsc_pkg::op_t  push_op,
    output logic          push_ready,
    input  logic          pop,
    output logic          pop_valid,
    output gsc_pkg::op_t  pop_op
);

    gsc_pkg::op_t entry_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         do_push;
    logic         do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// File: hw/rtl/gsc_front.sv
module gsc_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,  // [7:0] data_byte
    input  logic          s_tlast,  // last_byte
    output logic          push,
    output gsc_pkg::op_t  push_op,
    input  logic          push_ready
);

    gsc_pkg::phase_t phase_reg;
    gsc_pkg::phase_t phase_next;
    gsc_pkg::kind_t  kind_reg;
    gsc_pkg::kind_t  kind_next;
    logic [7:0]      field_reg;
    logic [7:0]      field_next;
    logic [3:0]      digits_reg;
    logic [3:0]      digits_next;
    logic [3:0]      need;
    logic            star_seen;
    gsc_pkg::nibble_t nib;

    assign s_tready = push_ready;
    assign push     = s_tvalid && push_ready;
    assign nib      = gsc_pkg::hex_nibble(s_tdata);

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        field_next  = field_reg;
        digits_next = digits_reg;

        push_op          = '0;
        push_op.data     = s_tdata;
        push_op.role     = gsc_pkg::ROLE_IGNORED;
        push_op.field    = field_reg;
        push_op.nib      = nib.value;
        push_op.nib_bad  = !nib.ok;

        case (phase_reg)
            gsc_pkg::PH_START:
            begin
                field_next    = 8'd0;
                digits_next   = 4'd0;
                push_op.clear = 1'b1;
                push_op.role  = gsc_pkg::ROLE_START;
                push_op.field = 8'd0;
                if (s_tdata == gsc_pkg::CH_DOLLAR)
                begin
                    kind_next  = gsc_pkg::KIND_NMEA;
                    phase_next = gsc_pkg::PH_BODY;
                end
                else if (s_tdata == gsc_pkg::CH_HASH)
                begin
                    kind_next  = gsc_pkg::KIND_CRC;
                    phase_next = gsc_pkg::PH_BODY;
                end
                else
                begin
                    kind_next  = gsc_pkg::KIND_NONE;
                    phase_next = gsc_pkg::PH_SKIP;
                end
            end
            gsc_pkg::PH_BODY:
            begin
                if (s_tdata == gsc_pkg::CH_STAR)
                begin
                    push_op.role = gsc_pkg::ROLE_STAR;
                    phase_next   = gsc_pkg::PH_DIGITS;
                end
                else
                begin
                    push_op.sum_en = 1'b1;
                    if (s_tdata == gsc_pkg::CH_COMMA ||
                        (s_tdata == gsc_pkg::CH_SEMI && kind_reg == gsc_pkg::KIND_CRC))
                    begin
                        push_op.role = gsc_pkg::ROLE_SEP;
                        if (field_reg != gsc_pkg::FIELD_MAX)
                        begin
                            field_next = field_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        push_op.role = gsc_pkg::ROLE_DATA;
                    end
                end
            end
            gsc_pkg::PH_DIGITS:
            begin
                push_op.role     = gsc_pkg::ROLE_DIGIT;
                push_op.digit_en = 1'b1;
                digits_next      = digits_reg + 4'd1;
                if (digits_next >= need)
                begin
                    phase_next = gsc_pkg::PH_TAIL;
                end
            end
            gsc_pkg::PH_TAIL:
            begin
                push_op.role = gsc_pkg::ROLE_TAIL;
            end
            default:
            begin
                push_op.role  = gsc_pkg::ROLE_IGNORED;
                push_op.field = 8'd0;
            end
        endcase

        star_seen = (phase_next == gsc_pkg::PH_DIGITS) || (phase_next == gsc_pkg::PH_TAIL);
        push_op.kind         = kind_next;
        push_op.star_seen    = star_seen;
        push_op.digits_short = star_seen && (digits_next < need);
        push_op.verdict      = s_tlast && (kind_next != gsc_pkg::KIND_NONE);

        if (s_tlast)
        begin
            phase_next = gsc_pkg::PH_START;
        end
    end

    // need only matters outside the start phase, where kind is already held
    assign need = (kind_reg == gsc_pkg::KIND_CRC) ? gsc_pkg::NEED_CRC : gsc_pkg::NEED_NMEA;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= gsc_pkg::PH_START;
            kind_reg   <= gsc_pkg::KIND_NONE;
            field_reg  <= 8'd0;
            digits_reg <= 4'd0;
        end
        else if (push)
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            field_reg  <= field_next;
            digits_reg <= digits_next;
        end
    end

endmodule

// File: hw/rtl/gsc_back.sv
module gsc_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    input  logic          cfg_data,
    input  logic          op_valid,
    input  gsc_pkg::op_t  op,
    output logic          op_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata,
    output logic [4:0]    m_tuser
);

    logic        crc_en_reg;
    logic [7:0]  xor_reg;
    logic [7:0]  xor_next;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] recv_reg;
    logic [31:0] recv_next;
    logic        bad_reg;
    logic        bad_next;
    logic        derr;
    logic        passed;
    logic [31:0] rx;
    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic [23:0] out_data_next;
    logic [4:0]  out_user_reg;
    logic [4:0]  out_user_next;

    assign op_pop   = op_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        if (op.clear)
        begin
            xor_next  = 8'd0;
            crc_next  = gsc_pkg::CRC_INIT;
            recv_next = 32'd0;
            bad_next  = 1'b0;
        end
        else
        begin
            xor_next  = op.sum_en ? (xor_reg ^ op.data) : xor_reg;
            crc_next  = op.sum_en ? gsc_pkg::crc_byte(crc_reg, op.data) : crc_reg;
            recv_next = op.digit_en ? {recv_reg[27:0], op.nib} : recv_reg;
            bad_next  = bad_reg | (op.digit_en & op.nib_bad);
        end

        derr   = bad_next | op.digits_short;
        rx     = op.star_seen ? recv_next : 32'd0;
        passed = 1'b0;
        if (op.kind == gsc_pkg::KIND_NMEA)
        begin
            passed = !derr && (xor_next == rx[7:0]);
        end
        else if (!crc_en_reg)
        begin
            passed = 1'b1;
        end
        else
        begin
            passed = !derr && (~crc_next == rx);
        end

        out_data_next = {5'd0, op.verdict & derr, op.verdict & passed, op.verdict,
                         op.data, op.field};
        out_user_next = {op.role, op.kind};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_en_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
            xor_reg       <= 8'd0;
            crc_reg       <= gsc_pkg::CRC_INIT;
            recv_reg      <= 32'd0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                crc_en_reg <= cfg_data;
            end
            if (op_pop)
            begin
                out_valid_reg <= 1'b1;
                xor_reg       <= xor_next;
                crc_reg       <= crc_next;
                recv_reg      <= recv_next;
                bad_reg       <= bad_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

endmodule

// File: hw/rtl/gsc_checker.sv
`include "assert_macros.svh"

module gsc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [4:0]  m_tuser
);

    logic role_ignored;
    logic role_start;

    assign role_ignored = (m_tuser[4:2] == gsc_pkg::ROLE_IGNORED);
    assign role_start   = (m_tuser[4:2] == gsc_pkg::ROLE_START);

    `GSC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `GSC_ASSERT_IMP(a_flags_need_verdict, m_tvalid && !m_tdata[16],
                    !m_tdata[17] && !m_tdata[18])
    `GSC_ASSERT_IMP(a_ignored_unknown, m_tvalid && role_ignored,
                    m_tuser[1:0] == gsc_pkg::KIND_NONE && m_tdata[7:0] == 8'd0 && !m_tdata[16])
    `GSC_ASSERT_IMP(a_start_field_zero, m_tvalid && role_start,
                    m_tdata[7:0] == 8'd0 && m_tdata[23:19] == 5'd0)

endmodule

bind gnss_sentence_checker gsc_checker u_gsc_checker (.*);

// File: dv/tb_gnss_sentence_checker.sv
module tb_gnss_sentence_checker;

    import gsc_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    typedef struct packed
    {
        kind_t      kind;
        role_t      role;
        logic [7:0] field;
        logic [7:0] echo;
        logic       verdict;
        logic       passed;
        logic       derr;
    } result_t;

    typedef struct packed
    {
        logic [7:0] b;
        logic       last;
        logic       typed;
        result_t    want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;     // [7:0] data_byte
    logic        s_tlast = 1'b0;     // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [7:0] field_number, [15:8] byte_echo, [16] verdict_ready,
                                     // [17] check_passed, [18] digit_error
    logic [4:0]  m_tuser;            // [1:0] sentence_kind, [4:2] byte_role
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;    // crc_check_enable

    gnss_sentence_checker dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    phase_t      seq_phase;
    kind_t       seq_kind;
    logic [7:0]  run_xor;
    logic [31:0] run_crc;
    logic [31:0] rx_sum;
    logic [3:0]  n_digits;
    logic [7:0]  n_fields;
    logic        digit_bad;
    logic        crc_enable;

    result_t     byte_results_due[$];
    logic [7:0]  sentence_bytes[$];
    dir_row_t    directed_rows[$];

    int errors = 0;
    int items_sent = 0;
    int sentences_sent = 0;
    int cfg_writes = 0;
    int burst_left = 0;
    logic sender_steady = 1'b0;
    int idle_cycles = 0;
    int rx_hold = 0;
    int n_dollar = 0, n_hash = 0, n_unknown = 0;
    int n_pass = 0, n_fail = 0, n_derr = 0;
    result_t want_r;

    function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b1, c[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10)
        begin
            return 8'h30 + {4'd0, n};
        end
        return (upper ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
    endfunction

    task automatic add_byte(input logic [7:0] c);
        sentence_bytes = {sentence_bytes, c};
    endtask

    task automatic add_row(input dir_row_t r);
        directed_rows = {directed_rows, r};
    endtask

    function automatic logic [7:0] body_char();
        int r;
        logic [7:0] c;
        r = $urandom_range(15);
        if (r < 3)
        begin
            return CH_COMMA;
        end
        if (r == 3)
        begin
            return CH_SEMI;
        end
        if (r == 4)
        begin
            c = 8'($urandom_range(255));
            return (c == CH_STAR) ? 8'h2B : c;
        end
        c = 8'($urandom_range(8'h30, 8'h5A));
        return c;
    endfunction

    function automatic dir_row_t plain_row(input logic [7:0] b, input logic last);
        dir_row_t r;
        r = '0;
        r.b = b;
        r.last = last;
        return r;
    endfunction

    function automatic dir_row_t typed_row(input logic [7:0] b, input logic last, input kind_t k,
                                           input role_t ro, input logic [7:0] f, input logic v,
                                           input logic p, input logic d);
        dir_row_t r;
        r = plain_row(b, last);
        r.typed = 1'b1;
        r.want.kind = k;
        r.want.role = ro;
        r.want.field = f;
        r.want.echo = b;
        r.want.verdict = v;
        r.want.passed = p;
        r.want.derr = d;
        return r;
    endfunction

    task automatic classify_byte(input logic [7:0] b, input logic last, output result_t r);
        logic [4:0] hv;
        logic [3:0] need;
        logic star_seen;
        logic [31:0] rx;
        r = '0;
        r.echo = b;
        case (seq_phase)
            PH_START:
            begin
                run_xor = 8'd0;
                run_crc = CRC_INIT;
                rx_sum = 32'd0;
                n_digits = 4'd0;
                n_fields = 8'd0;
                digit_bad = 1'b0;
                if (b == CH_DOLLAR)
                begin
                    seq_kind = KIND_NMEA;
                    seq_phase = PH_BODY;
                end
                else if (b == CH_HASH)
                begin
                    seq_kind = KIND_CRC;
                    seq_phase = PH_BODY;
                end
                else
                begin
                    seq_kind = KIND_NONE;
                    seq_phase = PH_SKIP;
                end
                r.role = ROLE_START;
            end
            PH_BODY:
            begin
                r.field = n_fields;
                if (b == CH_STAR)
                begin
                    r.role = ROLE_STAR;
                    seq_phase = PH_DIGITS;
                end
                else
                begin
                    if (b == CH_COMMA || (b == CH_SEMI && seq_kind == KIND_CRC))
                    begin
                        r.role = ROLE_SEP;
                        if (n_fields != FIELD_MAX)
                        begin
                            n_fields = n_fields + 8'd1;
                        end
                    end
                    else
                    begin
                        r.role = ROLE_DATA;
                    end
                    run_xor = run_xor ^ b;
                    run_crc = crc32_update(run_crc, b);
                end
            end
            PH_DIGITS:
            begin
                hv = hex_value(b);
                need = (seq_kind == KIND_CRC) ? NEED_CRC : NEED_NMEA;
                r.field = n_fields;
                r.role = ROLE_DIGIT;
                if (!hv[4])
                begin
                    digit_bad = 1'b1;
                end
                rx_sum = {rx_sum[27:0], hv[3:0]};
                n_digits = n_digits + 4'd1;
                if (n_digits >= need)
                begin
                    seq_phase = PH_TAIL;
                end
            end
            PH_TAIL:
            begin
                r.field = n_fields;
                r.role = ROLE_TAIL;
            end
            default:
            begin
                r.role = ROLE_IGNORED;
            end
        endcase
        r.kind = seq_kind;
        if (last && seq_kind != KIND_NONE)
        begin
            need = (seq_kind == KIND_CRC) ? NEED_CRC : NEED_NMEA;
            star_seen = (seq_phase == PH_DIGITS || seq_phase == PH_TAIL);
            r.derr = digit_bad || (star_seen && n_digits < need);
            r.verdict = 1'b1;
            rx = star_seen ? rx_sum : 32'd0;
            if (seq_kind == KIND_NMEA)
            begin
                r.passed = !r.derr && (run_xor == rx[7:0]);
            end
            else if (!crc_enable)
            begin
                r.passed = 1'b1;
            end
            else
            begin
                r.passed = !r.derr && (~run_crc == rx);
            end
        end
        if (last)
        begin
            seq_phase = PH_START;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input result_t want);
        result_t r;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        classify_byte(b, last, r);
        byte_results_due = {byte_results_due, (typed ? want : r)};
        items_sent++;
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else if (!sender_steady)
        begin
            burst_left = $urandom_range(0, 40);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (byte_results_due.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_crc_enable(input logic v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        crc_enable = v;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic make_sentence(input logic long_body);
        int sel, len, variant, ndig, cut;
        logic nmea;
        logic [7:0] xs;
        logic [31:0] crc, sum;
        logic [7:0] c;
        sentence_bytes.delete();
        sel = $urandom_range(99);
        if (sel < 15 && !long_body)
        begin
            len = $urandom_range(1, 10);
            repeat (len)
            begin
                c = 8'($urandom_range(255));
                add_byte(c);
            end
            return;
        end
        nmea = (sel < 55);
        // 1 no star, 2 digits cut short, 3 non-hex digit, 4 wrong sum
        variant = (sel >= 85) ? $urandom_range(1, 4) : 0;
        add_byte(nmea ? CH_DOLLAR : CH_HASH);
        xs = 8'd0;
        crc = CRC_INIT;
        len = long_body ? $urandom_range(256, 300) : $urandom_range(0, 14);
        for (int i = 0; i < len; i++)
        begin
            c = long_body ? CH_COMMA : body_char();
            xs = xs ^ c;
            crc = crc32_update(crc, c);
            add_byte(c);
        end
        if (variant == 1)
        begin
            return;
        end
        add_byte(CH_STAR);
        ndig = nmea ? 2 : 8;
        sum = nmea ? {24'd0, xs} : ~crc;
        if (variant == 4)
        begin
            sum = $urandom;
        end
        cut = (variant == 2) ? $urandom_range(0, ndig - 1) : ndig;
        for (int i = ndig - 1; i >= ndig - cut; i--)
        begin
            c = hex_char(sum[i * 4 +: 4], 1'($urandom_range(1)));
            add_byte(c);
        end
        if (variant == 2)
        begin
            return;
        end
        if (variant == 3)
        begin
            c = $urandom_range(1) ? 8'($urandom_range(8'h47, 8'h5A))
                                  : 8'($urandom_range(8'h67, 8'h7E));
            sentence_bytes[sentence_bytes.size() - 1 - $urandom_range(ndig - 1)] = c;
        end
        case ($urandom_range(3))
            0: ;
            1:
            begin
                add_byte(8'h0D);
                add_byte(8'h0A);
            end
            2: add_byte(8'h0A);
            default:
            begin
                repeat ($urandom_range(1, 3))
                begin
                    c = 8'($urandom_range(255));
                    add_byte(c);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (rx_hold == 0)
        begin
            case ($urandom_range(3))
                0:
                begin
                    m_tready <= 1'b1;
                    rx_hold = $urandom_range(100, 250);
                end
                1:
                begin
                    m_tready <= 1'b0;
                    rx_hold = $urandom_range(1, 12);
                end
                default:
                begin
                    m_tready <= 1'b1;
                    rx_hold = $urandom_range(1, 20);
                end
            endcase
        end
        else
        begin
            rx_hold = rx_hold - 1;
        end
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (m_tdata[23:19] !== 5'd0 || $isunknown({m_tdata, m_tuser}))
            begin
                $error("result transfer carries unknown or non-zero pad bits: %h %h",
                       m_tdata, m_tuser);
                errors++;
            end
            if (byte_results_due.size() == 0)
            begin
                $error("result transfer with nothing expected, byte_echo %0d", m_tdata[15:8]);
                errors++;
            end
            else
            begin
                want_r = byte_results_due.pop_front();
                check_field("sentence_kind", int'(want_r.kind), int'(m_tuser[1:0]));
                check_field("byte_role", int'(want_r.role), int'(m_tuser[4:2]));
                check_field("field_number", int'(want_r.field), int'(m_tdata[7:0]));
                check_field("byte_echo", int'(want_r.echo), int'(m_tdata[15:8]));
                check_field("verdict_ready", int'(want_r.verdict), int'(m_tdata[16]));
                check_field("check_passed", int'(want_r.passed), int'(m_tdata[17]));
                check_field("digit_error", int'(want_r.derr), int'(m_tdata[18]));
                if (want_r.role == ROLE_START)
                begin
                    if (want_r.kind == KIND_NMEA)
                        n_dollar++;
                    else if (want_r.kind == KIND_CRC)
                        n_hash++;
                    else
                        n_unknown++;
                end
                if (want_r.verdict)
                begin
                    if (want_r.passed)
                        n_pass++;
                    else
                        n_fail++;
                    if (want_r.derr)
                        n_derr++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no transfer for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int goal;
        logic long_done;
        long_done = 1'b0;
        crc_enable = 1'b1;
        seq_phase = PH_START;
        seq_kind = KIND_NONE;
        run_xor = 8'd0;
        run_crc = CRC_INIT;
        rx_sum = 32'd0;
        n_digits = 4'd0;
        n_fields = 8'd0;
        digit_bad = 1'b0;

        // single-byte sentences, unknown start, valid sum, bad and short digits, tail, no star
        add_row(typed_row(CH_DOLLAR, 1'b1, KIND_NMEA, ROLE_START, 8'd0, 1'b1, 1'b1, 1'b0));
        add_row(typed_row(CH_HASH, 1'b1, KIND_CRC, ROLE_START, 8'd0, 1'b1, 1'b1, 1'b0));
        add_row(typed_row(8'h00, 1'b0, KIND_NONE, ROLE_START, 8'd0, 1'b0, 1'b0, 1'b0));
        add_row(typed_row(8'hFF, 1'b1, KIND_NONE, ROLE_IGNORED, 8'd0, 1'b0, 1'b0, 1'b0));
        add_row(plain_row(CH_DOLLAR, 1'b0));
        add_row(plain_row(CH_COMMA, 1'b0));
        add_row(plain_row(8'h41, 1'b0));
        add_row(plain_row(CH_STAR, 1'b0));
        add_row(plain_row(8'h36, 1'b0));
        add_row(plain_row(8'h64, 1'b1));
        add_row(plain_row(CH_HASH, 1'b0));
        add_row(plain_row(CH_SEMI, 1'b0));
        add_row(plain_row(CH_STAR, 1'b0));
        add_row(typed_row(8'h47, 1'b1, KIND_CRC, ROLE_DIGIT, 8'd1, 1'b1, 1'b0, 1'b1));
        add_row(plain_row(CH_DOLLAR, 1'b0));
        add_row(plain_row(CH_STAR, 1'b0));
        add_row(plain_row(8'h30, 1'b0));
        add_row(plain_row(8'h30, 1'b0));
        add_row(plain_row(8'h0D, 1'b0));
        add_row(typed_row(8'h0A, 1'b1, KIND_NMEA, ROLE_TAIL, 8'd0, 1'b1, 1'b1, 1'b0));
        add_row(plain_row(CH_DOLLAR, 1'b0));
        add_row(typed_row(8'h41, 1'b1, KIND_NMEA, ROLE_DATA, 8'd0, 1'b1, 1'b0, 1'b0));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_crc_enable(1'b1);
        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].want);
        end
        sentences_sent += 7;
        wait_until_drained();

        for (int p = 0; p < 6; p++)
        begin
            write_crc_enable(p[0]);
            sender_steady = (p == 3);
            goal = items_sent + 305;
            while (items_sent < goal)
            begin
                make_sentence(!long_done);
                long_done = 1'b1;
                foreach (sentence_bytes[i])
                begin
                    send_byte(sentence_bytes[i], i == sentence_bytes.size() - 1, 1'b0, '0);
                end
                sentences_sent++;
                if ($urandom_range(24) == 0)
                begin
                    wait_until_drained();
                end
            end
            wait_until_drained();
        end

        repeat (8) @(posedge clk);
        $display("%0d bytes in %0d sentences, %0d enable writes;", items_sent, sentences_sent,
                 cfg_writes);
        $display("starts: '$' %0d, '#' %0d, other %0d; verdicts: %0d passed, %0d failed, %0d with digit errors",
                 n_dollar, n_hash, n_unknown, n_pass, n_fail, n_derr);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
